FILE: hw/rtl/qsip_pkg.sv
// ---------------------------------------------------------------------------
// qsip_pkg: shared types and helpers for the query string item parser
// Character codes, result kinds, phase encodings, hex and utf-8 step helpers.
// ---------------------------------------------------------------------------
package qsip_pkg;

	// item counter width
	localparam int COUNT_BITS = 16;

	// result queue depth
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// special characters
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PCT   = 8'h25;

	// configuration register indexes
	localparam logic CFG_PLUS_AS_SPACE = 1'b0;
	localparam logic CFG_ALLOW_QMARK   = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_BYTE     = 2'd0;
	localparam logic [1:0] KIND_ITEM_END = 2'd1;
	localparam logic [1:0] KIND_DONE     = 2'd2;

	// position within the query
	typedef enum logic [2:0] {
		POS_START   = 3'b001,
		POS_QMARK   = 3'b010,
		POS_CONTENT = 3'b100
	} pos_t;

	// percent escape progress
	typedef enum logic [2:0] {
		ESC_NONE = 3'b001,
		ESC_HIGH = 3'b010,
		ESC_LOW  = 3'b100
	} esc_t;

	// one result beat
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  decoded_byte;
		logic        in_value;
		logic        has_eq;
		logic [15:0] item_count;
		logic        status;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_res_t;

	typedef struct packed {
		logic       ok;
		logic [1:0] rem;
		logic [7:0] lo;
		logic [7:0] hi;
	} utf8_res_t;

	// hex digit in either case
	function automatic hex_res_t hex_digit(logic [7:0] c);
		hex_res_t r;
		r.ok  = 1'b1;
		r.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.val = 4'(c - 8'h37);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	// strict utf-8 check of one decoded byte
	function automatic utf8_res_t utf8_step(logic [7:0] b, logic [1:0] rem,
			logic [7:0] lo, logic [7:0] hi);
		utf8_res_t r;
		r.ok  = 1'b1;
		r.rem = rem;
		r.lo  = 8'h80;
		r.hi  = 8'hBF;
		if (rem != 2'd0) begin
			r.ok  = (b >= lo) && (b <= hi);
			r.rem = rem - 2'd1;
		end else if (b == 8'h00) begin
			r.ok = 1'b0;
		end else if (b < 8'h80) begin
			r.ok = 1'b1;
		end else if (b >= 8'hC2 && b <= 8'hDF) begin
			r.rem = 2'd1;
		end else if (b >= 8'hE0 && b <= 8'hEF) begin
			r.rem = 2'd2;
			if (b == 8'hE0) r.lo = 8'hA0;
			if (b == 8'hED) r.hi = 8'h9F;
		end else if (b >= 8'hF0 && b <= 8'hF4) begin
			r.rem = 2'd3;
			if (b == 8'hF0) r.lo = 8'h90;
			if (b == 8'hF4) r.hi = 8'h8F;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	// item count clipped to the 16-bit result field
	function automatic logic [15:0] sat16(logic [COUNT_BITS-1:0] c);
		logic [31:0] w;
		w = 32'(c);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

endpackage

FILE: hw/rtl/query_string_item_parser.sv
// ---------------------------------------------------------------------------
// query_string_item_parser: form-urlencoded query string decoder
// Splits items and key/value, decodes escapes, checks utf-8, counts items.
// ---------------------------------------------------------------------------
// Path: an accepted beat is held in the input register, then its results enter the queue.
// Throughput: one input beat per cycle; the end marker adds up to two results
// (item end and done) to the 4-entry result queue, and the input stage
// waits while that queue holds more than two results.
// Reset: arst_n clears the query state, the config registers and the queue.
module query_string_item_parser (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic        cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_query
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] decoded_byte, [8] has_eq,
	                               // [24:9] item_count, [25] status, rest 0
	output logic [2:0]  m_tuser    // [1:0] kind, [2] in_value
);

	localparam int CW = qsip_pkg::COUNT_BITS;
	localparam int QA = qsip_pkg::QAW;

	// config registers
	logic plus_as_space_q, allow_qmark_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoq_s1;

	// query state
	qsip_pkg::pos_t pos_q, pos_n;
	qsip_pkg::esc_t esc_q, esc_n;
	logic [3:0]     nib_q, nib_n;
	logic           seen_eq_q, seen_eq_n;
	logic [1:0]     urem_q, urem_n;
	logic [7:0]     ulo_q, ulo_n, uhi_q, uhi_n;
	logic           err_q, err_n;
	logic [CW-1:0]  items_q, items_n;

	// result queue
	qsip_pkg::result_t queue_q [qsip_pkg::QDEPTH];
	logic [QA-1:0]     wr_ptr_q, rd_ptr_q;
	logic [QA:0]       cnt_q;

	logic              adv;
	logic              pop;
	logic [1:0]        push_n;
	qsip_pkg::result_t r0, r1;

	logic              emit_req;
	logic [7:0]        emit_val;
	qsip_pkg::hex_res_t  hx;
	qsip_pkg::utf8_res_t u8;
	logic [7:0]        plain_b;

	// handshakes
	assign adv      = valid_s1 && (cnt_q <= (QA+1)'(qsip_pkg::QDEPTH - 2));
	assign s_tready = !valid_s1 || adv;
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != '0);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plus_as_space_q <= 1'b0;
			allow_qmark_q   <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				qsip_pkg::CFG_PLUS_AS_SPACE: plus_as_space_q <= cfg_data;
				qsip_pkg::CFG_ALLOW_QMARK:   allow_qmark_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eoq_s1  <= s_tlast;
		end
	end

	// per-byte decode and state update
	always_comb begin
		pos_n     = pos_q;
		esc_n     = esc_q;
		nib_n     = nib_q;
		seen_eq_n = seen_eq_q;
		urem_n    = urem_q;
		ulo_n     = ulo_q;
		uhi_n     = uhi_q;
		err_n     = err_q;
		items_n   = items_q;
		push_n    = 2'd0;
		r0        = '0;
		r1        = '0;
		emit_req  = 1'b0;
		emit_val  = 8'h00;
		hx        = qsip_pkg::hex_digit(byte_s1);
		plain_b   = (byte_s1 == qsip_pkg::CH_PLUS && plus_as_space_q) ?
			qsip_pkg::CH_SPACE : byte_s1;

		if (eoq_s1) begin
			// end marker: close open item, then report done
			err_n = err_q || (esc_q != qsip_pkg::ESC_NONE) || (urem_q != 2'd0);
			if (!err_n && pos_q == qsip_pkg::POS_CONTENT) begin
				r0.kind      = qsip_pkg::KIND_ITEM_END;
				r0.has_eq    = seen_eq_q;
				if (items_q != '1) items_n = items_q + CW'(1);
				r1.kind       = qsip_pkg::KIND_DONE;
				r1.item_count = qsip_pkg::sat16(items_n);
				r1.status     = err_n;
				push_n        = 2'd2;
			end else begin
				r0.kind       = qsip_pkg::KIND_DONE;
				r0.item_count = qsip_pkg::sat16(items_n);
				r0.status     = err_n;
				push_n        = 2'd1;
			end
			pos_n     = qsip_pkg::POS_START;
			esc_n     = qsip_pkg::ESC_NONE;
			nib_n     = 4'd0;
			seen_eq_n = 1'b0;
			urem_n    = 2'd0;
			ulo_n     = 8'h80;
			uhi_n     = 8'hBF;
			err_n     = 1'b0;
			items_n   = '0;
		end else if (!err_q) begin
			if (pos_q == qsip_pkg::POS_START && allow_qmark_q &&
					byte_s1 == qsip_pkg::CH_QMARK) begin
				// skipped leading question mark
				pos_n = qsip_pkg::POS_QMARK;
			end else begin
				pos_n = qsip_pkg::POS_CONTENT;
				if (esc_q != qsip_pkg::ESC_NONE) begin
					// hex digits of an escape
					if (!hx.ok) begin
						err_n = 1'b1;
					end else if (esc_q == qsip_pkg::ESC_HIGH) begin
						nib_n = hx.val;
						esc_n = qsip_pkg::ESC_LOW;
					end else begin
						esc_n    = qsip_pkg::ESC_NONE;
						emit_req = 1'b1;
						emit_val = {nib_q, hx.val};
					end
				end else if (byte_s1 == qsip_pkg::CH_AMP) begin
					// item separator
					if (urem_q != 2'd0) begin
						err_n = 1'b1;
					end else begin
						r0.kind      = qsip_pkg::KIND_ITEM_END;
						r0.has_eq    = seen_eq_q;
						push_n       = 2'd1;
						if (items_q != '1) items_n = items_q + CW'(1);
						seen_eq_n = 1'b0;
						urem_n    = 2'd0;
						ulo_n     = 8'h80;
						uhi_n     = 8'hBF;
					end
				end else if (byte_s1 == qsip_pkg::CH_EQ && !seen_eq_q) begin
					// key/value split
					if (urem_q != 2'd0) begin
						err_n = 1'b1;
					end else begin
						seen_eq_n = 1'b1;
						urem_n    = 2'd0;
						ulo_n     = 8'h80;
						uhi_n     = 8'hBF;
					end
				end else if (byte_s1 == qsip_pkg::CH_PCT) begin
					esc_n = qsip_pkg::ESC_HIGH;
				end else begin
					emit_req = 1'b1;
					emit_val = plain_b;
				end
			end
		end

		// utf-8 check and byte result
		u8 = qsip_pkg::utf8_step(emit_val, urem_q, ulo_q, uhi_q);
		if (emit_req) begin
			if (!u8.ok) begin
				err_n = 1'b1;
			end else begin
				urem_n          = u8.rem;
				ulo_n           = u8.lo;
				uhi_n           = u8.hi;
				r0.kind         = qsip_pkg::KIND_BYTE;
				r0.decoded_byte = emit_val;
				r0.in_value     = seen_eq_q;
				push_n          = 2'd1;
			end
		end
	end

	// query state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= qsip_pkg::POS_START;
			esc_q     <= qsip_pkg::ESC_NONE;
			nib_q     <= 4'd0;
			seen_eq_q <= 1'b0;
			urem_q    <= 2'd0;
			ulo_q     <= 8'h80;
			uhi_q     <= 8'hBF;
			err_q     <= 1'b0;
			items_q   <= '0;
		end else if (adv) begin
			pos_q     <= pos_n;
			esc_q     <= esc_n;
			nib_q     <= nib_n;
			seen_eq_q <= seen_eq_n;
			urem_q    <= urem_n;
			ulo_q     <= ulo_n;
			uhi_q     <= uhi_n;
			err_q     <= err_n;
			items_q   <= items_n;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (adv) wr_ptr_q <= wr_ptr_q + QA'(push_n);
			if (pop) rd_ptr_q <= rd_ptr_q + QA'(1);
			cnt_q <= cnt_q + (QA+1)'(adv ? push_n : 2'd0) - (QA+1)'(pop);
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (adv && push_n != 2'd0) queue_q[wr_ptr_q] <= r0;
		if (adv && push_n == 2'd2) queue_q[wr_ptr_q + QA'(1)] <= r1;
	end

	// output packing
	always_comb begin
		qsip_pkg::result_t h;
		h       = queue_q[rd_ptr_q];
		m_tdata = {6'd0, h.status, h.item_count, h.has_eq, h.decoded_byte};
		m_tuser = {h.in_value, h.kind};
	end

	// queue never overfills
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QA+1)'(qsip_pkg::QDEPTH))
		else $error("result queue overflow");

	// once malformed, bytes give no result
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && !eoq_s1 && err_q |-> push_n == 2'd0)
		else $error("result after error");

	// end marker returns the query state to its start
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && eoq_s1 |=> pos_q == qsip_pkg::POS_START && !err_q && items_q == '0)
		else $error("query state not cleared after end marker");

endmodule
